// File: sv/pfs_pkg.sv
// Package with the word types, codes and constants of the pulse FIFO sample stream block.
`default_nettype none

package pfs_pkg;

	// Default number of slots in the pulse ring; one slot always stays free.
	localparam int FIFO_DEPTH_DEF = 4096;

	// Field widths of the words on the two channels.
	localparam int PERIOD_W = 32;
	localparam int RATE_W   = 18;
	localparam int THR_W    = 7;
	localparam int SAMPLE_W = 8;
	localparam int FILL_W   = 12;
	localparam int CFG_W    = RATE_W;

	// Width of period_us times sample_rate.
	localparam int PROD_W = PERIOD_W + RATE_W;

	// Microseconds per second, the divisor of the period conversion.
	localparam int US_PER_SEC = 1000000;
	// Width of the remainder left after the reciprocal quotient estimate, which stays
	// below three times US_PER_SEC.
	localparam int REM_W = $clog2(3 * US_PER_SEC);

	// Scale of the fill percent.
	localparam int FILL_SCALE = 100;

	// Wait values reported by a push.
	localparam int WAIT_GOOD_A    = 50;
	localparam int WAIT_GOOD_B    = 150;
	localparam int WAIT_NOT_READY = 100;
	localparam int WAIT_READY     = 1;

	// Sample values for a high and a low pin level.
	localparam logic [SAMPLE_W-1:0] SAMPLE_HIGH = 8'hFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_LOW  = 8'h00;

	// Register reset values.
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
	localparam logic [THR_W-1:0]  THR_RESET  = 7'd1;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_PULL  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic {
		CFG_SAMPLE_RATE     = 1'b0,
		CFG_LEVEL_THRESHOLD = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]          action;
		logic                level;
		logic [PERIOD_W-1:0] period_us;
		logic                paused;
	} item_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [PERIOD_W-1:0] next_wait_us;
		logic                overflow;
		logic [FILL_W-1:0]   fill_count;
	} result_word_t;

	// One queued pulse: its pin level and the samples it still has to give.
	typedef struct packed {
		logic                level;
		logic [PERIOD_W-1:0] count;
	} pulse_entry_t;

	// Request to the period converter.
	typedef struct packed {
		logic                start;
		logic [PERIOD_W-1:0] period_us;
		logic [RATE_W-1:0]   rate;
	} conv_req_t;

	// Answer of the period converter; samples holds until the next start.
	typedef struct packed {
		logic                done;
		logic [PERIOD_W-1:0] samples;
	} conv_rsp_t;

endpackage

`default_nettype wire

// File: sv/pulse_fifo_to_sample_stream_top.sv
// Top level of the pulse FIFO sample stream block: control, pointers, registers and result word.
//
// The block keeps a ring FIFO of tape pulses, each a pin level and a length in output
// samples, and turns them into an 8-bit audio sample stream. Each word on the item
// channel carries an action: push a pulse, pull one sample, or clear the FIFO. Every
// item gives exactly one word on the result channel, in order.
// A push converts period_us into samples through a multiply and a division by one
// million done as a reciprocal multiply with a small correction, registered in turn
// as product, quotient estimate, remainder and corrected quotient. A push gives its
// result word once the converter is done and the result register can take it.
// A pull reads the head pulse from the pulse memory, decrements its count and writes
// it back. Pulls, clears and other actions go straight to the finish state and give
// their result word as soon as the result register can take it.
// One item is in work at a time, so the read and the write back never overlap.
// The result word sits in an output register: while the receiver stalls, the block
// still accepts and works on the next item, and holds it until that register frees.
// Configuration writes take effect at once and are meant for idle periods only.
// Reset empties the FIFO, clears the ready flag and the last sample, and returns the
// registers to 44100 samples per second and a threshold of one percent. The pulse
// memory needs no clearing pass: only entries written by a push are ever read.
`default_nettype none

module pulse_fifo_to_sample_stream_top import pfs_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire item_word_t       item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output result_word_t          result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int PW = $clog2(FIFO_DEPTH);
	// Wide enough for fill*100 and for (threshold+1)*FIFO_DEPTH.
	localparam int CMP_W = PW + 9;
	localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);
	localparam logic [PW:0]   DEPTH_W   = (PW + 1)'(FIFO_DEPTH);

	// Number of pulses between read and write pointer, with wrap-around.
	function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] wp, input logic [PW-1:0] rp);
		logic [PW:0] diff;
		diff = (PW + 1)'(wp) - (PW + 1)'(rp);
		if (wp < rp) begin
			diff = diff + DEPTH_W;
		end
		return diff[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST_SLOT) ? '0 : (p + 1'b1);
	endfunction

	function automatic logic [FILL_W-1:0] fill_field(input logic [PW-1:0] f);
		logic [PW+FILL_W-1:0] wide;
		wide = (PW + FILL_W)'(f);
		return wide[FILL_W-1:0];
	endfunction

	state_t state_q, state_d;

	// Configuration registers.
	logic [RATE_W-1:0] rate_q;
	logic [THR_W-1:0]  thr_q;

	// FIFO and stream state.
	logic [PW-1:0]       rp_q, wp_q;
	logic [SAMPLE_W-1:0] last_q;
	logic                ready_q;

	// Item in work and the result register.
	item_word_t   item_q;
	result_word_t result_q;
	logic         result_valid_q;

	logic accept;
	logic commit;
	logic out_free;

	conv_req_t conv_req;
	conv_rsp_t conv_rsp;

	pulse_entry_t rd_data;
	pulse_entry_t wr_data;
	logic         mem_we;
	logic         wr_req;
	logic [PW-1:0] wr_addr;

	result_word_t        res;
	logic [PW-1:0]       rp_d, wp_d;
	logic [SAMPLE_W-1:0] last_d;
	logic                ready_d;

	pfs_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (conv_req),
		.rsp    (conv_rsp)
	);

	pfs_store #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rp_q),
		.rd_data (rd_data)
	);

	assign out_free = !result_valid_q || result_ready;

	// Next state: a push waits for the converter, every item ends in the finish state,
	// which leaves as soon as the result register can take the word.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = (item.action == ACT_PUSH) ? ST_CONV : ST_FIN;
				end
			end
			ST_CONV: begin
				if (conv_rsp.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State machine outputs.
	always_comb begin
		item_ready         = 1'b0;
		commit             = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
			end
			ST_FIN: begin
				commit = out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
		accept             = item_valid && item_ready;
		conv_req.start     = accept && (item.action == ACT_PUSH);
		conv_req.period_us = item.period_us;
		conv_req.rate      = rate_q;
	end

	// Result of the item in work and the state it leaves. The head pulse read at
	// acceptance is in rd_data; nothing touches the pointers before the commit.
	always_comb begin
		logic [PW-1:0]       fill_new;
		logic [CMP_W-1:0]    lhs;
		logic [CMP_W-1:0]    rhs;
		logic [PERIOD_W:0]   long_wait;
		logic [SAMPLE_W-1:0] head_sample;
		logic                done;

		res      = '0;
		rp_d     = rp_q;
		wp_d     = wp_q;
		last_d   = last_q;
		ready_d  = ready_q;
		wr_req   = 1'b0;
		wr_addr  = wp_q;
		wr_data  = '0;
		fill_new = '0;
		lhs      = '0;
		rhs      = '0;
		long_wait   = '0;
		head_sample = '0;
		done        = 1'b0;

		case (item_q.action)
			ACT_PUSH: begin
				if (ptr_inc(wp_q) != rp_q) begin
					wr_req        = 1'b1;
					wr_addr       = wp_q;
					wr_data.level = item_q.level;
					wr_data.count = conv_rsp.samples;
					wp_d          = ptr_inc(wp_q);
				end else begin
					res.overflow = 1'b1;
				end
				fill_new = fill_of(wp_d, rp_q);
				// floor(fill*100/depth) > thr is the same as fill*100 >= (thr+1)*depth.
				lhs = CMP_W'(fill_new) * CMP_W'(FILL_SCALE);
				rhs = CMP_W'({1'b0, thr_q} + 1'b1) * CMP_W'(FIFO_DEPTH);
				long_wait = {1'b0, item_q.period_us} + (PERIOD_W + 1)'(WAIT_GOOD_A + WAIT_GOOD_B);
				if ((lhs >= rhs) || item_q.paused) begin
					ready_d = 1'b1;
					res.next_wait_us = long_wait[PERIOD_W] ? '1 : long_wait[PERIOD_W-1:0];
				end else begin
					res.next_wait_us = ready_q ? PERIOD_W'(WAIT_READY) : PERIOD_W'(WAIT_NOT_READY);
				end
			end
			ACT_PULL: begin
				if (ready_q) begin
					if (rp_q != wp_q) begin
						head_sample = rd_data.level ? SAMPLE_HIGH : SAMPLE_LOW;
						last_d      = head_sample;
						wr_addr     = rp_q;
						wr_data.level = rd_data.level;
						if (rd_data.count != '0) begin
							wr_req        = 1'b1;
							wr_data.count = rd_data.count - 1'b1;
							done          = (rd_data.count == PERIOD_W'(1));
						end else begin
							done = 1'b1;
						end
						if (done) begin
							rp_d = ptr_inc(rp_q);
						end
					end
					res.sample = last_d;
				end
			end
			ACT_CLEAR: begin
				rp_d    = '0;
				wp_d    = '0;
				last_d  = '0;
				ready_d = 1'b0;
			end
			default: begin
				res.sample = '0;
			end
		endcase

		res.fill_count = fill_field(fill_of(wp_d, rp_d));
	end

	assign mem_we = commit && wr_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			thr_q  <= THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SAMPLE_RATE: begin
					rate_q <= cfg_data[RATE_W-1:0];
				end
				CFG_LEVEL_THRESHOLD: begin
					thr_q <= cfg_data[THR_W-1:0];
				end
				default: begin
					rate_q <= rate_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			wp_q    <= '0;
			last_q  <= '0;
			ready_q <= 1'b0;
		end else if (commit) begin
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			last_q  <= last_d;
			ready_q <= ready_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (commit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// File: sv/pfs_store.sv
// Pulse store: one synchronous memory with a write port and a registered read port.
`default_nettype none

module pfs_store import pfs_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(FIFO_DEPTH)-1:0] wr_addr,
	input  wire pulse_entry_t                  wr_data,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(FIFO_DEPTH)-1:0] rd_addr,
	output pulse_entry_t                       rd_data
);

	pulse_entry_t mem_q [FIFO_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/pfs_conv.sv
// Period converter: registered multiply, then division by one million through a reciprocal.
`default_nettype none

module pfs_conv import pfs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire conv_req_t req,
	output conv_rsp_t      rsp
);

	// The product bits above HI_LSB, times 2^51/10^6 rounded down and shifted right by 31, give a quotient
	// estimate that is never above the true quotient and at most two below it.
	localparam int HI_LSB      = 20;
	localparam int HI_W        = PROD_W - HI_LSB;
	localparam int RECIP_SHIFT = 31;
	localparam int RECIP_W     = 32;
	localparam int EST_W       = HI_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << (HI_LSB + RECIP_SHIFT)) / 64'(US_PER_SEC));

	logic vld_s1, vld_s2, vld_s3;
	logic done_q;

	logic [PROD_W-1:0]   prod_s1;
	logic [REM_W-1:0]    prod_lo_s2;
	logic [PERIOD_W-1:0] q0_s2;
	logic [PERIOD_W-1:0] q0_s3;
	logic [REM_W-1:0]    rem_s3;
	logic [PERIOD_W-1:0] quo_q;

	logic [EST_W-1:0]    est;
	logic [REM_W-1:0]    back;
	logic [PERIOD_W-1:0] quo_next;

	// The remainder is below 2^REM_W, so its low bits alone give it exactly.
	always_comb begin
		est  = EST_W'(prod_s1[PROD_W-1:HI_LSB]) * EST_W'(RECIP);
		back = q0_s2[REM_W-1:0] * REM_W'(US_PER_SEC);
		if (rem_s3 >= REM_W'(2 * US_PER_SEC)) begin
			quo_next = q0_s3 + PERIOD_W'(2);
		end else if (rem_s3 >= REM_W'(US_PER_SEC)) begin
			quo_next = q0_s3 + PERIOD_W'(1);
		end else begin
			quo_next = q0_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_s1 <= PROD_W'(req.period_us) * PROD_W'(req.rate);
		end
		if (vld_s1) begin
			prod_lo_s2 <= prod_s1[REM_W-1:0];
			q0_s2      <= PERIOD_W'(est[EST_W-1:RECIP_SHIFT]);
		end
		if (vld_s2) begin
			q0_s3  <= q0_s2;
			rem_s3 <= prod_lo_s2 - back;
		end
		if (vld_s3) begin
			quo_q <= quo_next;
		end
	end

	assign rsp.done    = done_q;
	assign rsp.samples = quo_q;

endmodule

`default_nettype wire
